/* src/dnme_pkg.sv */
// ----------------------------------------------------------------------------
// dnme_pkg
// shared types and constants for the descriptor nearest-match block
// ----------------------------------------------------------------------------
package dnme_pkg;

  localparam int KnownRows   = 64;
  localparam int UnknownRows = 64;
  localparam int MaxLength   = 128;

  localparam int RowW  = $clog2(KnownRows);
  localparam int URowW = $clog2(UnknownRows);
  localparam int ElemW = $clog2(MaxLength);
  localparam int DistW = 41;

  // queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic [1:0] CfgThr = 2'd0;
  localparam logic [1:0] CfgKnown = 2'd1;
  localparam logic [1:0] CfgLen = 2'd2;
  localparam logic [1:0] CfgRep = 2'd3;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // item passed from front to back through the queue
  typedef struct packed {
    logic              is_query;
    logic              last;
    logic [RowW-1:0]   entry;
    logic [ElemW-1:0]  element;
    logic              in_range;
    logic [15:0]       value;
  } item_t;

  typedef struct packed {
    logic [6:0]  class_index;
    logic [5:0]  unknown_slot;
    logic [15:0] sighting_count;
    logic        enrolled;
    logic        report_due;
    logic        table_full;
  } result_t;

endpackage

/* src/dnme_ram.sv */
// ----------------------------------------------------------------------------
// dnme_ram
// generic single-port-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dnme_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/dnme_front.sv */
// ----------------------------------------------------------------------------
// dnme_front
// accepts items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module dnme_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [5:0]           in_entry,
  input  logic [6:0]           in_element,
  input  logic signed [15:0]   in_value,
  input  logic                 in_last,
  output logic                 q_valid,
  output dnme_pkg::item_t      q_item,
  input  logic                 q_pop
);

  localparam int CntW = dnme_pkg::QPtrW + 1;

  dnme_pkg::item_t          fifo_r [dnme_pkg::QueueDepth];
  logic [dnme_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [CntW-1:0]          cnt_r;
  dnme_pkg::item_t          it;
  logic                     push;

  always_comb begin
    it.is_query = (in_cmd == dnme_pkg::CmdQuery);
    it.last     = in_last;
    it.entry    = in_entry[dnme_pkg::RowW-1:0];
    it.element  = in_element[dnme_pkg::ElemW-1:0];
    it.in_range = 1'b1;
    it.value    = in_value;
  end

  // hold off only when the queue is full, order is kept by the queue
  assign busy    = (cnt_r == CntW'(dnme_pkg::QueueDepth));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= it;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + CntW'(push) - CntW'(q_pop);
    end
  end

endmodule

/* src/dnme_back.sv */
// ----------------------------------------------------------------------------
// dnme_back
// table writes, distance search, sighting update and enrollment
// ----------------------------------------------------------------------------
module dnme_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  dnme_pkg::item_t      q_item,
  output logic                 q_pop,
  input  logic [40:0]          thr,
  input  logic [6:0]           known_entries,
  input  logic [7:0]           desc_len,
  input  logic [15:0]          report_count,
  output logic                 res_valid,
  output dnme_pkg::result_t    res
);

  localparam int KAW = dnme_pkg::RowW + dnme_pkg::ElemW;
  localparam int UAW = dnme_pkg::URowW + dnme_pkg::ElemW;

  typedef enum logic [3:0] {
    S_IDLE, S_KROW, S_KACC, S_KEND, S_UROW, S_UACC, S_UEND,
    S_CNTRD, S_DECIDE, S_COPY
  } state_t;

  state_t state_r;
  logic [dnme_pkg::ElemW:0]  ei_r;      // element counter, pipelined read
  logic [dnme_pkg::RowW:0]   row_r;
  logic [dnme_pkg::URowW:0]  used_r;
  logic [dnme_pkg::ElemW:0]  len_r;
  logic [dnme_pkg::RowW:0]   rows_r;
  logic [47:0]               sum_r;
  logic [47:0]               best_r;
  logic                      best_inf_r, found_r, khit_r;
  logic [dnme_pkg::RowW-1:0] idx_r;
  logic                      rd_v_r;    // read data valid this cycle
  logic                      rd_v2_r;
  logic [31:0]               sq_r;
  logic                      res_valid_r;
  dnme_pkg::result_t         res_r;

  // memories
  logic               kwe, uwe, qwe, cwe;
  logic [KAW-1:0]     kwa, kra;
  logic [UAW-1:0]     uwa, ura;
  logic [dnme_pkg::ElemW-1:0] qwa, qra;
  logic [15:0]        kwd, qwd, kq, uq, qq, cq, cwd;
  logic [dnme_pkg::URowW-1:0] cwa, cra;

  dnme_ram #(.Width(16), .Depth(dnme_pkg::KnownRows*dnme_pkg::MaxLength)) u_known (
    .clk, .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(kq));
  dnme_ram #(.Width(16), .Depth(dnme_pkg::UnknownRows*dnme_pkg::MaxLength)) u_unk (
    .clk, .we(uwe), .waddr(uwa), .wdata(qq), .raddr(ura), .rdata(uq));
  dnme_ram #(.Width(16), .Depth(dnme_pkg::MaxLength)) u_query (
    .clk, .we(qwe), .waddr(qwa), .wdata(qwd), .raddr(qra), .rdata(qq));
  dnme_ram #(.Width(16), .Depth(dnme_pkg::UnknownRows)) u_cnt (
    .clk, .we(cwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(cq));

  logic [dnme_pkg::ElemW-1:0] e_idx;
  logic                       in_elem;
  logic signed [16:0]         diff;
  logic [16:0]                adiff;
  logic [15:0]                cinc;
  logic                       is_ucnt;

  assign e_idx   = ei_r[dnme_pkg::ElemW-1:0];
  assign in_elem = (ei_r < len_r);
  assign kwe = (state_r == S_IDLE) && q_valid && !q_item.is_query;
  assign kwa = {q_item.entry, q_item.element};
  assign kwd = q_item.value;
  assign qwe = (state_r == S_IDLE) && q_valid && q_item.is_query;
  assign qwa = q_item.element;
  assign qwd = q_item.value;
  assign kra = {row_r[dnme_pkg::RowW-1:0], e_idx};
  assign ura = (state_r == S_COPY) ? {used_r[dnme_pkg::URowW-1:0], e_idx}
                                   : {row_r[dnme_pkg::URowW-1:0], e_idx};
  assign qra = e_idx;
  // copy writes land in the cycle after the query buffer read
  assign uwe = (state_r == S_COPY) && rd_v_r;
  assign uwa = {used_r[dnme_pkg::URowW-1:0], ei_r[dnme_pkg::ElemW-1:0] - 1'b1};
  assign cra = idx_r;
  assign q_pop = (state_r == S_IDLE) && q_valid;

  assign diff  = (khit_r ? $signed({kq[15], kq}) : $signed({uq[15], uq}))
                 - $signed({qq[15], qq});
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);
  assign cinc  = cq + 16'd1;
  assign is_ucnt = (state_r == S_DECIDE) && found_r && !best_inf_r
                   && (best_r <= 48'(thr)) && (cq != 16'hFFFF);
  assign cwe = is_ucnt || ((state_r == S_DECIDE) && !(found_r && !best_inf_r
               && best_r <= 48'(thr)) && used_r < 7'(dnme_pkg::UnknownRows));
  assign cwa = is_ucnt ? idx_r : used_r[dnme_pkg::URowW-1:0];
  assign cwd = is_ucnt ? cinc : 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      res_valid_r <= 1'b0;
      ei_r <= '0; row_r <= '0; rd_v_r <= 1'b0; rd_v2_r <= 1'b0;
      khit_r <= 1'b0;
    end else begin
      res_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_item.is_query && q_item.last) begin
            len_r  <= (desc_len > 8'(dnme_pkg::MaxLength)) ?
                      8'(dnme_pkg::MaxLength) : desc_len;
            rows_r <= (known_entries > 7'(dnme_pkg::KnownRows)) ?
                      7'(dnme_pkg::KnownRows) : known_entries;
            best_inf_r <= 1'b1; found_r <= 1'b0;
            best_r <= '0; idx_r <= '0;
            row_r <= '0; khit_r <= 1'b1;
            state_r <= S_KROW;
          end
        end
        S_KROW: begin
          if (row_r >= rows_r) begin
            state_r <= S_KEND;
          end else begin
            ei_r <= '0; sum_r <= '0; rd_v_r <= 1'b0; rd_v2_r <= 1'b0;
            state_r <= S_KACC;
          end
        end
        S_KACC, S_UACC: begin
          // read, square, accumulate: three stages in flight
          rd_v_r  <= in_elem;
          if (in_elem) ei_r <= ei_r + 1'b1;
          if (rd_v_r) sq_r <= 32'(adiff) * 32'(adiff);
          rd_v2_r <= rd_v_r;
          if (rd_v2_r) sum_r <= sum_r + 48'(sq_r);
          if (!in_elem && !rd_v_r && !rd_v2_r) begin
            if (best_inf_r || sum_r < best_r) begin
              best_r <= sum_r; best_inf_r <= 1'b0; found_r <= 1'b1;
              idx_r <= row_r[dnme_pkg::RowW-1:0];
            end
            row_r   <= row_r + 1'b1;
            state_r <= (state_r == S_KACC) ? S_KROW : S_UROW;
          end
        end
        S_KEND: begin
          if (found_r && best_r < 48'(thr)) begin
            res_r <= '{class_index: 7'(idx_r) + 7'd1, unknown_slot: '0,
                       sighting_count: '0, enrolled: 1'b0,
                       report_due: 1'b0, table_full: 1'b0};
            res_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            found_r <= 1'b0; row_r <= '0; khit_r <= 1'b0;
            state_r <= S_UROW;
          end
        end
        S_UROW: begin
          if (row_r >= 7'(used_r)) begin
            state_r <= S_UEND;
          end else begin
            ei_r <= '0; sum_r <= '0; rd_v_r <= 1'b0; rd_v2_r <= 1'b0;
            state_r <= S_UACC;
          end
        end
        S_UEND: state_r <= S_CNTRD;   // count ram read of idx_r
        S_CNTRD: state_r <= S_DECIDE;
        S_DECIDE: begin
          res_valid_r <= 1'b1;
          if (found_r && !best_inf_r && best_r <= 48'(thr)) begin
            res_r <= '{class_index: '0, unknown_slot: 6'(idx_r),
                       sighting_count: (cq == 16'hFFFF) ? cq : cinc,
                       enrolled: 1'b0,
                       report_due: (cq != 16'hFFFF) && (cinc == report_count),
                       table_full: 1'b0};
            state_r <= S_IDLE;
          end else if (used_r < 7'(dnme_pkg::UnknownRows)) begin
            res_r <= '{class_index: '0, unknown_slot: 6'(used_r),
                       sighting_count: 16'd1, enrolled: 1'b1,
                       report_due: 1'b0, table_full: 1'b0};
            ei_r <= '0; rd_v_r <= 1'b0;
            state_r <= S_COPY;
          end else begin
            res_r <= '{class_index: '0, unknown_slot: '0,
                       sighting_count: '0, enrolled: 1'b0,
                       report_due: 1'b0, table_full: 1'b1};
            state_r <= S_IDLE;
          end
        end
        S_COPY: begin
          // full buffer copied, whatever the length
          rd_v_r <= (ei_r < 8'(dnme_pkg::MaxLength));
          if (ei_r < 8'(dnme_pkg::MaxLength)) begin
            ei_r <= ei_r + 1'b1;
          end else begin
            used_r  <= used_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* src/descriptor_nearest_match_enroll.sv */
// ----------------------------------------------------------------------------
// descriptor_nearest_match_enroll
// open-set nearest-neighbour matcher with enrollment of unknown descriptors
// ----------------------------------------------------------------------------
// Items are accepted on start while busy is low and go through a four-entry
// queue. The back end writes a load or a non-final query element to its
// table while idle. A final query element runs the search over one
// multiply-accumulate unit over the known rows and, failing a match, the
// unknown rows, and may enroll the query. The result strobes out_valid for
// one cycle and cannot be held off; busy rises when the queue is full.
module descriptor_nearest_match_enroll (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_cmd,
  input  logic [5:0]          in_entry,
  input  logic [6:0]          in_element,
  input  logic signed [15:0]  in_value,
  input  logic                in_last,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [40:0]         cfg_data,
  output logic                out_valid,
  output logic [6:0]          out_class_index,
  output logic [5:0]          out_unknown_slot,
  output logic [15:0]         out_sighting_count,
  output logic                out_enrolled,
  output logic                out_report_due,
  output logic                out_table_full
);

  logic [40:0] thr_r;
  logic [6:0]  known_r;
  logic [7:0]  len_r;
  logic [15:0] rep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= 41'd42949673;
      known_r <= '0;
      len_r   <= 8'd128;
      rep_r   <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        dnme_pkg::CfgThr:   thr_r   <= cfg_data;
        dnme_pkg::CfgKnown: known_r <= cfg_data[6:0];
        dnme_pkg::CfgLen:   len_r   <= cfg_data[7:0];
        dnme_pkg::CfgRep:   rep_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic              q_valid, q_pop;
  dnme_pkg::item_t   q_item;
  dnme_pkg::result_t res;

  dnme_front u_front (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_entry, .in_element,
    .in_value, .in_last, .q_valid, .q_item, .q_pop);

  dnme_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .thr(thr_r),
    .known_entries(known_r), .desc_len(len_r), .report_count(rep_r),
    .res_valid(out_valid), .res);

  assign out_class_index    = res.class_index;
  assign out_unknown_slot   = res.unknown_slot;
  assign out_sighting_count = res.sighting_count;
  assign out_enrolled       = res.enrolled;
  assign out_report_due     = res.report_due;
  assign out_table_full     = res.table_full;

  // at most one outcome per result
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_class_index != 7'd0, out_enrolled,
                              out_table_full}) <= 1)
    else $error("result carries more than one outcome");

  a_enroll_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enrolled |-> out_sighting_count == 16'd1)
    else $error("enrolled item without count one");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
